// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/ukst_pkg.sv =====
// ----------------------------------------------------------------------------
// ukst_pkg
// Types and constants shared by the unique key set table.
// ----------------------------------------------------------------------------
package ukst_pkg;

  // Default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int CMD_W        = 2;
  localparam int KEY_PORT_W   = 32;
  localparam int IDX_W        = 4;
  localparam int COUNT_PORT_W = 5;
  localparam int STATUS_W     = 2;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_OOB  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_RWAIT
  } state_e;

endpackage

// ===== rtl/ukst_mem.sv =====
// ----------------------------------------------------------------------------
// ukst_mem
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ukst_mem #(
  parameter int DEPTH = ukst_pkg::CAPACITY_DEF,
  parameter int WIDTH = ukst_pkg::KEY_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/unique_key_set_table.sv =====
// ----------------------------------------------------------------------------
// unique_key_set_table
// Ordered set of distinct keys with add, remove, query and indexed read.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; the result shows on
// the result ports for one cycle with result_valid_o and must be captured
// then, since there is no way to hold it off. All work goes through one key
// comparator and one storage read port, one stored entry per cycle. Add,
// query and a remove that misses scan every stored entry; a match ends the
// scan early. A remove that hits then moves every entry behind it down one
// per cycle through the single read port. A read out of range ends in
// S_READ; one in range goes on through S_RWAIT. busy stays high from the
// accept edge until the strobe cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unique_key_set_table #(
  parameter int CAPACITY  = ukst_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ukst_pkg::KEY_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ukst_pkg::CMD_W-1:0]         cmd_i,
  input  logic [ukst_pkg::KEY_PORT_W-1:0]    key_value_i,
  input  logic [ukst_pkg::IDX_W-1:0]         read_index_i,
  output logic                               result_valid_o,
  output logic                               present_o,
  output logic [ukst_pkg::KEY_PORT_W-1:0]    read_key_o,
  output logic [ukst_pkg::COUNT_PORT_W-1:0]  entry_count_o,
  output logic [ukst_pkg::STATUS_W-1:0]      status_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > ukst_pkg::IDX_W) ? CNTW : ukst_pkg::IDX_W;
  localparam int OUTW = (CNTW > ukst_pkg::COUNT_PORT_W) ? CNTW : ukst_pkg::COUNT_PORT_W;
  localparam int KXW  = (KEY_WIDTH > ukst_pkg::KEY_PORT_W) ? KEY_WIDTH : ukst_pkg::KEY_PORT_W;

  ukst_pkg::state_e state_q, state_d;
  ukst_pkg::cmd_e   cmd_q;
  logic [KEY_WIDTH-1:0]        key_q;
  logic [ukst_pkg::IDX_W-1:0]  idx_q;
  logic [CNTW-1:0]             cnt_q, cnt_d;
  logic [CNTW-1:0]             ptr_q, ptr_d;
  logic                        rdv_q, rdv_d;

  logic                        accept;
  logic                        hit;
  logic [KXW-1:0]              key_ext;
  logic [KXW-1:0]              rd_ext;
  logic [CMPW-1:0]             idx_ext;
  logic [CMPW-1:0]             cnt_cmp;
  logic [CNTW-1:0]             wptr;
  logic [OUTW-1:0]             cnt_out;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [KEY_WIDTH-1:0]        mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [KEY_WIDTH-1:0]        mem_rdata;

  logic                        emit;
  logic                        emit_present;
  ukst_pkg::status_e           emit_status;
  logic [ukst_pkg::KEY_PORT_W-1:0] emit_rdkey;

  logic                        res_valid_q;
  logic                        present_q;
  logic [ukst_pkg::KEY_PORT_W-1:0] read_key_q;
  ukst_pkg::status_e           status_q;

  // Key storage
  ukst_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Width adaption of keys, index and count
  assign busy    = (state_q != ukst_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign key_ext = KXW'(key_value_i);
  assign rd_ext  = KXW'(mem_rdata);
  assign idx_ext = CMPW'(idx_q);
  assign cnt_cmp = CMPW'(cnt_q);
  assign wptr    = ptr_q - CNTW'(2);
  assign cnt_out = OUTW'(cnt_q);

  // Shared comparator: stored entry against the item's key
  assign hit = rdv_q && (mem_rdata == key_q);

  // Sequencer: next state, storage access and result
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    rdv_d        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = ptr_q[AW-1:0];
    mem_wdata    = key_q;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[AW-1:0];
    emit         = 1'b0;
    emit_present = 1'b0;
    emit_status  = ukst_pkg::STAT_OK;
    emit_rdkey   = '0;
    case (state_q)
      ukst_pkg::S_IDLE: begin
        if (accept) begin
          ptr_d = '0;
          if (ukst_pkg::cmd_e'(cmd_i) == ukst_pkg::CMD_READ) begin
            state_d = ukst_pkg::S_READ;
          end else begin
            state_d = ukst_pkg::S_SCAN;
          end
        end
      end
      ukst_pkg::S_SCAN: begin
        if (hit) begin
          // Key found at ptr_q - 1
          if (cmd_q == ukst_pkg::CMD_REMOVE) begin
            state_d = ukst_pkg::S_SHIFT;
          end else begin
            emit         = 1'b1;
            emit_present = 1'b1;
            state_d      = ukst_pkg::S_IDLE;
          end
        end else if (ptr_q < cnt_q) begin
          // Fetch the next entry
          mem_re = 1'b1;
          ptr_d  = ptr_q + CNTW'(1);
          rdv_d  = 1'b1;
        end else begin
          // Key absent
          emit    = 1'b1;
          state_d = ukst_pkg::S_IDLE;
          if (cmd_q == ukst_pkg::CMD_ADD) begin
            if (cnt_q < CNTW'(CAPACITY)) begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[AW-1:0];
              cnt_d     = cnt_q + CNTW'(1);
            end else begin
              emit_status = ukst_pkg::STAT_FULL;
            end
          end
        end
      end
      ukst_pkg::S_SHIFT: begin
        // Move each later entry down by one
        if (rdv_q) begin
          mem_we    = 1'b1;
          mem_waddr = wptr[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (ptr_q < cnt_q) begin
          mem_re = 1'b1;
          ptr_d  = ptr_q + CNTW'(1);
          rdv_d  = 1'b1;
        end else if (!rdv_q) begin
          cnt_d        = cnt_q - CNTW'(1);
          emit         = 1'b1;
          emit_present = 1'b1;
          state_d      = ukst_pkg::S_IDLE;
        end
      end
      ukst_pkg::S_READ: begin
        if (idx_ext < cnt_cmp) begin
          mem_re    = 1'b1;
          mem_raddr = idx_ext[AW-1:0];
          state_d   = ukst_pkg::S_RWAIT;
        end else begin
          emit        = 1'b1;
          emit_status = ukst_pkg::STAT_OOB;
          state_d     = ukst_pkg::S_IDLE;
        end
      end
      ukst_pkg::S_RWAIT: begin
        emit       = 1'b1;
        emit_rdkey = rd_ext[ukst_pkg::KEY_PORT_W-1:0];
        state_d    = ukst_pkg::S_IDLE;
      end
      default: begin
        state_d = ukst_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ukst_pkg::S_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rdv_q       <= rdv_d;
      res_valid_q <= emit;
    end
  end

  // Capture the item and hold the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= ukst_pkg::cmd_e'(cmd_i);
      key_q <= key_ext[KEY_WIDTH-1:0];
      idx_q <= read_index_i;
    end
    if (emit) begin
      present_q  <= emit_present;
      read_key_q <= emit_rdkey;
      status_q   <= emit_status;
    end
  end

  assign result_valid_o = res_valid_q;
  assign present_o      = present_q;
  assign read_key_o     = read_key_q;
  assign entry_count_o  = cnt_out[ukst_pkg::COUNT_PORT_W-1:0];
  assign status_o       = status_q;

  // Checks
  `ASSERT_PROP(a_strobe_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result strobe held over two cycles")
  `ASSERT_PROP(a_accept_busy, clk_i, rst_ni, accept |=> busy, "busy low after an accepted item")
  `ASSERT_PROP(a_count_at_result, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> result_valid_o, "count changed without a result")
  `ASSERT_NEVER(a_full_count, clk_i, rst_ni, result_valid_o && (status_q == ukst_pkg::STAT_FULL) && (cnt_q != CNTW'(CAPACITY)), "full status with room left")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unique key set table. A short table of probe
// items covers reset, the key extremes, duplicates, a full table, a front
// remove and bad read indexes; a long random part follows, drawn mostly from
// a small key pool and the stored keys so that the table fills, drains and
// sees real hits. Every item is predicted in order of acceptance and every
// strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ukst_pkg::*;

  localparam int SLOTS       = CAPACITY_DEF;
  localparam int RAND_ITEMS  = 1800;
  localparam int QUIET_FROM  = 1500;
  localparam int POOL_SIZE   = 24;
  localparam int PROBE_ROWS  = 26;
  localparam int TAIL_CYCLES = 48;
  localparam int CYCLE_LIMIT = 600000;

  // One result of the block
  typedef struct packed {
    logic                    present;
    logic [KEY_PORT_W-1:0]   read_key;
    logic [COUNT_PORT_W-1:0] count;
    status_e                 status;
  } set_result_t;

  // One row of the probe table; want is used only where typed is set
  typedef struct {
    cmd_e              cmd;
    logic [KEY_PORT_W-1:0] key;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    set_result_t       want;
  } probe_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [CMD_W-1:0]        cmd_i;
  logic [KEY_PORT_W-1:0]   key_value_i;
  logic [IDX_W-1:0]        read_index_i;
  logic                    result_valid_o;
  logic                    present_o;
  logic [KEY_PORT_W-1:0]   read_key_o;
  logic [COUNT_PORT_W-1:0] entry_count_o;
  logic [STATUS_W-1:0]     status_o;

  // Predicted contents of the set
  logic [KEY_PORT_W-1:0] key_table [SLOTS];
  int                    key_count;

  set_result_t           pending_results[$];
  logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];
  probe_row_t            probe_rows [PROBE_ROWS];
  int                    mismatches;
  int                    results_seen;
  int                    op_total [4];
  int                    full_drops;
  int                    bad_reads;
  int                    cycle_count;

  unique_key_set_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .key_value_i    (key_value_i),
    .read_index_i   (read_index_i),
    .result_valid_o (result_valid_o),
    .present_o      (present_o),
    .read_key_o     (read_key_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one operation to the predicted set and return its result
  function automatic set_result_t apply_to_set(input cmd_e op, input logic [KEY_PORT_W-1:0] k,
                                               input logic [IDX_W-1:0] ix);
    set_result_t r;
    int          pos;
    r        = '0;
    r.status = STAT_OK;
    pos      = -1;
    if (op == CMD_READ) begin
      if (ix < key_count) begin
        r.read_key = key_table[ix];
      end else begin
        r.status = STAT_OOB;
      end
    end else begin
      for (int i = 0; i < key_count; i++) begin
        if (pos < 0 && key_table[i] == k) pos = i;
      end
      r.present = (pos >= 0);
      if (op == CMD_ADD && pos < 0) begin
        if (key_count < SLOTS) begin
          key_table[key_count] = k;
          key_count++;
        end else begin
          r.status = STAT_FULL;
        end
      end else if (op == CMD_REMOVE && pos >= 0) begin
        // close the gap, keeping insertion order
        for (int i = pos; i + 1 < key_count; i++) key_table[i] = key_table[i + 1];
        key_count--;
      end
    end
    r.count = key_count[COUNT_PORT_W-1:0];
    return r;
  endfunction

  function automatic probe_row_t mk_row(input cmd_e op, input logic [KEY_PORT_W-1:0] k,
                                        input logic [IDX_W-1:0] ix, input bit typed,
                                        input logic p, input logic [KEY_PORT_W-1:0] rk,
                                        input int cnt, input status_e st);
    probe_row_t row;
    row.cmd           = op;
    row.key           = k;
    row.idx           = ix;
    row.typed         = typed;
    row.want.present  = p;
    row.want.read_key = rk;
    row.want.count    = cnt[COUNT_PORT_W-1:0];
    row.want.status   = st;
    return row;
  endfunction

  // Present one item and hold it until the block takes it
  task automatic issue_item(input cmd_e op, input logic [KEY_PORT_W-1:0] k,
                            input logic [IDX_W-1:0] ix, input bit typed,
                            input set_result_t want);
    set_result_t r;
    start        <= 1'b1;
    cmd_i        <= op;
    key_value_i  <= k;
    read_index_i <= ix;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = apply_to_set(op, k, ix);
    if (r.status == STAT_FULL) full_drops++;
    if (r.status == STAT_OOB) bad_reads++;
    op_total[op]++;
    pending_results.insert(pending_results.size(), typed ? want : r);
  endtask

  // Drop start and put noise on the item fields for an idle stretch set by n
  task automatic idle_cycles(input int n);
    start        <= 1'b0;
    cmd_i        <= CMD_W'($urandom);
    key_value_i  <= $urandom;
    read_index_i <= IDX_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_PORT_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && key_count > 0) return key_table[$urandom_range(0, key_count - 1)];
    if (roll < 8) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (key_count > 0 && $urandom_range(0, 3) != 0) begin
      return IDX_W'($urandom_range(0, key_count - 1));
    end
    return IDX_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Operation mix follows the phase: fill, drain or even
  function automatic cmd_e pick_cmd(input int phase);
    int roll;
    roll = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (roll < 60) return CMD_ADD;
        if (roll < 70) return CMD_REMOVE;
        return (roll < 85) ? CMD_QUERY : CMD_READ;
      end
      1: begin
        if (roll < 15) return CMD_ADD;
        if (roll < 70) return CMD_REMOVE;
        return (roll < 85) ? CMD_QUERY : CMD_READ;
      end
      default: begin
        return cmd_e'(roll % 4);
      end
    endcase
  endfunction

  // Capture each strobed result and compare it with the oldest prediction
  always @(posedge clk_i) begin : check_results
    set_result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: count %0d status %0d",
               entry_count_o, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (present_o !== want.present) begin
          $error("present: expected %0d, got %0d", want.present, present_o);
          mismatches++;
        end
        if (read_key_o !== want.read_key) begin
          $error("read_key: expected %h, got %h", want.read_key, read_key_o);
          mismatches++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    set_result_t none;
    cmd_e        op;
    bit          quiet;
    none         = '0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_ADD;
    key_value_i  = '0;
    read_index_i = '0;
    mismatches   = 0;
    results_seen = 0;
    full_drops   = 0;
    bad_reads    = 0;
    key_count    = 0;
    foreach (op_total[i]) op_total[i] = 0;
    foreach (key_table[i]) key_table[i] = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Probe table: typed rows carry their expected result directly
    probe_rows[0] = mk_row(CMD_READ,   32'h0,         4'd0,  1, 0, 32'h0, 0, STAT_OOB);
    probe_rows[1] = mk_row(CMD_QUERY,  32'h0,         4'd9,  1, 0, 32'h0, 0, STAT_OK);
    probe_rows[2] = mk_row(CMD_REMOVE, 32'hFFFF_FFFF, 4'd0,  1, 0, 32'h0, 0, STAT_OK);
    probe_rows[3] = mk_row(CMD_ADD,    32'h0,         4'd15, 1, 0, 32'h0, 1, STAT_OK);
    probe_rows[4] = mk_row(CMD_ADD,    32'hFFFF_FFFF, 4'd0,  1, 0, 32'h0, 2, STAT_OK);
    probe_rows[5] = mk_row(CMD_ADD,    32'h0,         4'd0,  1, 1, 32'h0, 2, STAT_OK);
    probe_rows[6] = mk_row(CMD_READ,   32'h1234_5678, 4'd1,  1, 0, 32'hFFFF_FFFF, 2, STAT_OK);
    probe_rows[7] = mk_row(CMD_READ,   32'h0,         4'd15, 1, 0, 32'h0, 2, STAT_OOB);
    for (int i = 0; i < 14; i++) begin
      probe_rows[8 + i] = mk_row(CMD_ADD, 32'h5A5A_0001 + i, 4'(i), 0, 0, 32'h0, 0, STAT_OK);
    end
    probe_rows[22] = mk_row(CMD_ADD,    32'h1234_5678, 4'd0,  1, 0, 32'h0, 16, STAT_FULL);
    probe_rows[23] = mk_row(CMD_ADD,    32'h0,         4'd0,  1, 1, 32'h0, 16, STAT_OK);
    probe_rows[24] = mk_row(CMD_REMOVE, 32'h0,         4'd0,  1, 1, 32'h0, 15, STAT_OK);
    probe_rows[25] = mk_row(CMD_READ,   32'h0,         4'd15, 1, 0, 32'h0, 15, STAT_OOB);

    // Hold reset, then release on a clock edge
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the probe table
    foreach (probe_rows[i]) begin
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 11));
      issue_item(probe_rows[i].cmd, probe_rows[i].key, probe_rows[i].idx,
                 probe_rows[i].typed, probe_rows[i].want);
    end
    drain_results();

    // Random part in phases; quiet stretches and the tail run items with no idle gaps
    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = ((n / 100) % 4 == 3) || (n >= QUIET_FROM);
      if (!quiet && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 11));
      if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
      op = pick_cmd((n / 150) % 3);
      issue_item(op, pick_key(), pick_index(), 0, none);
      if (n % 300 == 299) drain_results();
    end

    // Wait out the last results, then a short tail for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d adds, %0d removes, %0d queries, %0d reads; %0d results checked",
             op_total[CMD_ADD], op_total[CMD_REMOVE], op_total[CMD_QUERY],
             op_total[CMD_READ], results_seen);
    $display("Adds dropped on a full table: %0d, out-of-range reads: %0d, mismatches: %0d",
             full_drops, bad_reads, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
